/* hdl/dtb_pkg.sv */
// Shared types and constants of the dominator tree builder.
// Used by dtb_engine and dominator_tree_builder_top; no dependencies.
package dtb_pkg;

  localparam int unsigned IdW      = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned EdgeAw   = 8;
  localparam int unsigned EdgeCntW = 9;
  localparam int unsigned EdgeW    = 2 * IdW;
  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned MaxEdges  = 256;
  localparam int unsigned StkW     = EdgeCntW + IdW;

  localparam logic CfgBlockCount = 1'b0;
  localparam logic CfgEntryBlock = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_W_SCAN,
    S_W_CHK,
    S_W_POP,
    S_N_RD,
    S_N_WR,
    S_P_RD,
    S_P_B,
    S_P_E,
    S_P_EC,
    S_M_RD,
    S_M_CMP,
    S_M_UPD,
    S_P_UPD,
    S_D_RD,
    S_D_B,
    S_D_P,
    S_D_W,
    S_O_RD,
    S_O_WR
  } state_e;

  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] blk_idx;
    logic           reachable;
    logic [IdW-1:0] imm_dom;
    logic [IdW-1:0] depth;
    logic           overflow;
    logic           last;
  } res_t;

endpackage

/* hdl/dominator_tree_builder_top.sv */
// Top level of the dominator tree builder: configuration, edge store, result ports.
// Depends on dtb_pkg and dtb_engine.
//
// Usage: a transfer is taken when start is high and busy is low. With
// command_i low it adds the edge src_block_i -> dst_block_i in that cycle and
// busy stays low, so edges load one per cycle. Edges naming a block not
// below block_count (capped at MaxBlocks), or arriving with MaxEdges held, are
// dropped and raise a sticky overflow flag.
// With command_i high the block goes busy, walks the graph depth first from
// the entry block register, runs intersect passes, derives depths, then
// emits one result per block id in order, each on the result ports for one
// cycle under result_valid_o, last_o on the final one. An entry block not
// below the block count skips straight to emission. The run ends with the
// edge count and overflow flag cleared; a zero block count ends it at once
// with no result. The receiver cannot stall. Configuration is written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i, by the user only while idle; the block
// does not enforce it. Reset clears the edge count, the flag and both registers.
module dominator_tree_builder_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      command_i,
  input  logic [dtb_pkg::IdW-1:0]   src_block_i,
  input  logic [dtb_pkg::IdW-1:0]   dst_block_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [dtb_pkg::CntW-1:0]  cfg_wdata_i,
  output logic                      result_valid_o,
  output logic [dtb_pkg::IdW-1:0]   blk_idx_o,
  output logic                      reachable_o,
  output logic [dtb_pkg::IdW-1:0]   imm_dominator_o,
  output logic [dtb_pkg::IdW-1:0]   tree_depth_o,
  output logic                      overflow_o,
  output logic                      last_o
);

  logic [dtb_pkg::CntW-1:0]     block_count_q;
  logic [dtb_pkg::IdW-1:0]      root_blk_q;
  logic [dtb_pkg::EdgeCntW-1:0] edge_total_q;
  logic                         ovf_q;
  logic [dtb_pkg::EdgeW-1:0]    edge_mem [dtb_pkg::MaxEdges];
  logic [dtb_pkg::EdgeW-1:0]    edge_rd_q;
  logic [dtb_pkg::EdgeAw-1:0]   edge_ra;
  logic [dtb_pkg::CntW-1:0]     n;
  logic                         take, add, edge_ok, go, done, eng_busy;
  dtb_pkg::res_t                res;

  assign n       = (block_count_q > 7'(dtb_pkg::MaxBlocks)) ? 7'(dtb_pkg::MaxBlocks)
                                                            : block_count_q;
  assign take    = start && !eng_busy;
  assign add     = take && !command_i;
  assign go      = take && command_i;
  assign edge_ok = ({1'b0, src_block_i} < n) && ({1'b0, dst_block_i} < n) &&
                   (edge_total_q < 9'(dtb_pkg::MaxEdges));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
      root_blk_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtb_pkg::CfgBlockCount: block_count_q <= cfg_wdata_i;
        dtb_pkg::CfgEntryBlock: root_blk_q    <= cfg_wdata_i[dtb_pkg::IdW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      ovf_q        <= 1'b0;
    end else if (done) begin
      edge_total_q <= '0;
      ovf_q        <= 1'b0;
    end else if (add) begin
      if (edge_ok) begin
        edge_total_q <= edge_total_q + 9'd1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add && edge_ok) begin
      edge_mem[edge_total_q[dtb_pkg::EdgeAw-1:0]] <= {src_block_i, dst_block_i};
    end
    edge_rd_q <= edge_mem[edge_ra];
  end

  dtb_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (go),
    .n_i          (n),
    .root_i       (root_blk_q),
    .edge_total_i (edge_total_q),
    .ovf_i        (ovf_q),
    .edge_rd_i    (edge_rd_q),
    .edge_ra_o    (edge_ra),
    .busy_o       (eng_busy),
    .done_o       (done),
    .res_o        (res)
  );

  assign busy            = eng_busy;
  assign result_valid_o  = res.valid;
  assign blk_idx_o       = res.blk_idx;
  assign reachable_o     = res.reachable;
  assign imm_dominator_o = res.imm_dom;
  assign tree_depth_o    = res.depth;
  assign overflow_o      = res.overflow;
  assign last_o          = res.last;

endmodule

/* hdl/dtb_engine.sv */
// Compute sequencer: depth-first numbering, intersect passes, depths, emission.
// Holds the postorder, order, stack, dominator and depth memories. Depends on dtb_pkg.
module dtb_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [dtb_pkg::CntW-1:0]      n_i,
  input  logic [dtb_pkg::IdW-1:0]       root_i,
  input  logic [dtb_pkg::EdgeCntW-1:0]  edge_total_i,
  input  logic                          ovf_i,
  input  logic [dtb_pkg::EdgeW-1:0]     edge_rd_i,
  output logic [dtb_pkg::EdgeAw-1:0]    edge_ra_o,
  output logic                          busy_o,
  output logic                          done_o,
  output dtb_pkg::res_t                 res_o
);

  localparam int unsigned IdW = dtb_pkg::IdW;
  localparam int unsigned Ids = 1 << IdW;

  dtb_pkg::state_e state_q, state_d;
  logic [dtb_pkg::CntW-1:0]     top_q, top_d, cnt_q, cnt_d, idx_q, idx_d;
  logic [IdW-1:0]               cur_b_q, cur_b_d, b_q, b_d, pick_q, pick_d;
  logic [IdW-1:0]               ma_q, ma_d, mb_q, mb_d;
  logic [dtb_pkg::EdgeCntW-1:0] cur_e_q, cur_e_d, e_q, e_d;
  logic                         have_q, have_d, chg_q, chg_d, sel_q, sel_d;
  logic [7:0]                   pass_q, pass_d;
  logic [Ids-1:0]               vis_q, vis_d, vld_q, vld_d;
  dtb_pkg::res_t                res_q, res_d;

  logic [IdW-1:0] post_mem [Ids];
  logic [IdW-1:0] ord_mem  [Ids];
  logic [dtb_pkg::StkW-1:0] stk_mem [Ids];
  logic [IdW-1:0] dom_mem  [Ids];
  logic [IdW-1:0] dep_mem  [Ids];

  logic                     post_we, ord_we, stk_we, dom_we, dep_we;
  logic [IdW-1:0]           post_wa, ord_wa, stk_wa, dom_wa, dep_wa;
  logic [IdW-1:0]           post_wd, ord_wd, dom_wd, dep_wd;
  logic [dtb_pkg::StkW-1:0] stk_wd, stk_rd_q;
  logic [IdW-1:0]           post_ra, ord_ra0, ord_ra1, stk_ra, dom_ra, dep_ra;
  logic [IdW-1:0]           post_rd_q, ord_rd0_q, ord_rd1_q, dom_rd_q, dep_rd_q;

  logic [dtb_pkg::CntW-1:0] rev;
  logic [IdW-1:0]           es, ed;

  assign rev = cnt_q - 7'd1 - idx_q;
  assign es  = edge_rd_i[dtb_pkg::EdgeW-1:IdW];
  assign ed  = edge_rd_i[IdW-1:0];

  always_ff @(posedge clk_i) begin
    if (post_we) post_mem[post_wa] <= post_wd;
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (dom_we) dom_mem[dom_wa] <= dom_wd;
    if (dep_we) dep_mem[dep_wa] <= dep_wd;
    post_rd_q <= post_mem[post_ra];
    ord_rd0_q <= ord_mem[ord_ra0];
    ord_rd1_q <= ord_mem[ord_ra1];
    stk_rd_q  <= stk_mem[stk_ra];
    dom_rd_q  <= dom_mem[dom_ra];
    dep_rd_q  <= dep_mem[dep_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtb_pkg::S_IDLE;
      top_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      cur_b_q <= '0;
      cur_e_q <= '0;
      b_q     <= '0;
      e_q     <= '0;
      pick_q  <= '0;
      ma_q    <= '0;
      mb_q    <= '0;
      have_q  <= 1'b0;
      chg_q   <= 1'b0;
      sel_q   <= 1'b0;
      pass_q  <= '0;
      vis_q   <= '0;
      vld_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      cur_b_q <= cur_b_d;
      cur_e_q <= cur_e_d;
      b_q     <= b_d;
      e_q     <= e_d;
      pick_q  <= pick_d;
      ma_q    <= ma_d;
      mb_q    <= mb_d;
      have_q  <= have_d;
      chg_q   <= chg_d;
      sel_q   <= sel_d;
      pass_q  <= pass_d;
      vis_q   <= vis_d;
      vld_q   <= vld_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d = state_q;
    top_d   = top_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    cur_b_d = cur_b_q;
    cur_e_d = cur_e_q;
    b_d     = b_q;
    e_d     = e_q;
    pick_d  = pick_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    have_d  = have_q;
    chg_d   = chg_q;
    sel_d   = sel_q;
    pass_d  = pass_q;
    vis_d   = vis_q;
    vld_d   = vld_q;
    res_d   = res_q;
    res_d.valid = 1'b0;
    done_o  = 1'b0;
    edge_ra_o = '0;
    post_we = 1'b0; post_wa = '0; post_wd = '0; post_ra = '0;
    ord_we  = 1'b0; ord_wa  = '0; ord_wd  = '0; ord_ra0 = '0; ord_ra1 = '0;
    stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;
    dom_we  = 1'b0; dom_wa  = '0; dom_wd  = '0; dom_ra  = '0;
    dep_we  = 1'b0; dep_wa  = '0; dep_wd  = '0; dep_ra  = '0;

    case (state_q)
      dtb_pkg::S_IDLE: begin
        if (go_i) begin
          vis_d = '0;
          vld_d = '0;
          idx_d = '0;
          if (n_i == '0) begin
            done_o = 1'b1;
          end else if ({1'b0, root_i} >= n_i) begin
            state_d = dtb_pkg::S_O_RD;
          end else begin
            vis_d[root_i] = 1'b1;
            top_d   = 7'd1;
            cur_b_d = root_i;
            cur_e_d = '0;
            cnt_d   = '0;
            state_d = dtb_pkg::S_W_SCAN;
          end
        end
      end
      dtb_pkg::S_W_SCAN: begin
        if (cur_e_q >= edge_total_i) begin
          post_we = 1'b1;
          post_wa = cnt_q[IdW-1:0];
          post_wd = cur_b_q;
          cnt_d   = cnt_q + 7'd1;
          if (top_q == 7'd1) begin
            idx_d   = '0;
            state_d = dtb_pkg::S_N_RD;
          end else begin
            stk_ra  = 6'(top_q - 7'd2);
            top_d   = top_q - 7'd1;
            state_d = dtb_pkg::S_W_POP;
          end
        end else begin
          edge_ra_o = cur_e_q[dtb_pkg::EdgeAw-1:0];
          state_d   = dtb_pkg::S_W_CHK;
        end
      end
      dtb_pkg::S_W_CHK: begin
        cur_e_d = cur_e_q + 9'd1;
        if (es == cur_b_q && {1'b0, ed} < n_i && !vis_q[ed] && top_q < 7'(Ids)) begin
          stk_we = 1'b1;
          stk_wa = 6'(top_q - 7'd1);
          stk_wd = {cur_e_q + 9'd1, cur_b_q};
          cur_b_d = ed;
          cur_e_d = '0;
          top_d   = top_q + 7'd1;
          vis_d[ed] = 1'b1;
        end
        state_d = dtb_pkg::S_W_SCAN;
      end
      dtb_pkg::S_W_POP: begin
        {cur_e_d, cur_b_d} = stk_rd_q;
        state_d = dtb_pkg::S_W_SCAN;
      end
      dtb_pkg::S_N_RD: begin
        post_ra = idx_q[IdW-1:0];
        state_d = dtb_pkg::S_N_WR;
      end
      dtb_pkg::S_N_WR: begin
        ord_we = 1'b1;
        ord_wa = post_rd_q;
        ord_wd = rev[IdW-1:0];
        idx_d  = idx_q + 7'd1;
        state_d = dtb_pkg::S_N_RD;
        if (idx_q + 7'd1 == cnt_q) begin
          dom_we = 1'b1;
          dom_wa = root_i;
          dom_wd = root_i;
          vld_d[root_i] = 1'b1;
          idx_d  = '0;
          chg_d  = 1'b0;
          pass_d = 8'd1;
          state_d = dtb_pkg::S_P_RD;
        end
      end
      dtb_pkg::S_P_RD: begin
        if (idx_q == cnt_q) begin
          idx_d = '0;
          if (chg_q && pass_q < 8'(2 * Ids)) begin
            pass_d  = pass_q + 8'd1;
            chg_d   = 1'b0;
            state_d = dtb_pkg::S_P_RD;
          end else begin
            state_d = dtb_pkg::S_D_RD;
          end
        end else begin
          post_ra = rev[IdW-1:0];
          state_d = dtb_pkg::S_P_B;
        end
      end
      dtb_pkg::S_P_B: begin
        b_d = post_rd_q;
        if (post_rd_q == root_i) begin
          idx_d   = idx_q + 7'd1;
          state_d = dtb_pkg::S_P_RD;
        end else begin
          e_d     = '0;
          have_d  = 1'b0;
          state_d = dtb_pkg::S_P_E;
        end
      end
      dtb_pkg::S_P_E: begin
        if (e_q >= edge_total_i) begin
          dom_ra  = b_q;
          state_d = dtb_pkg::S_P_UPD;
        end else begin
          edge_ra_o = e_q[dtb_pkg::EdgeAw-1:0];
          state_d   = dtb_pkg::S_P_EC;
        end
      end
      dtb_pkg::S_P_EC: begin
        e_d     = e_q + 9'd1;
        state_d = dtb_pkg::S_P_E;
        if (ed == b_q && {1'b0, es} < n_i && vld_q[es]) begin
          if (!have_q) begin
            pick_d = es;
            have_d = 1'b1;
          end else begin
            ma_d    = pick_q;
            mb_d    = es;
            state_d = dtb_pkg::S_M_RD;
          end
        end
      end
      dtb_pkg::S_M_RD: begin
        if (ma_q == mb_q) begin
          pick_d  = ma_q;
          state_d = dtb_pkg::S_P_E;
        end else begin
          ord_ra0 = ma_q;
          ord_ra1 = mb_q;
          state_d = dtb_pkg::S_M_CMP;
        end
      end
      dtb_pkg::S_M_CMP: begin
        sel_d   = ord_rd0_q > ord_rd1_q;
        dom_ra  = (ord_rd0_q > ord_rd1_q) ? ma_q : mb_q;
        state_d = dtb_pkg::S_M_UPD;
      end
      dtb_pkg::S_M_UPD: begin
        if (sel_q) begin
          ma_d = dom_rd_q;
        end else begin
          mb_d = dom_rd_q;
        end
        state_d = dtb_pkg::S_M_RD;
      end
      dtb_pkg::S_P_UPD: begin
        if (have_q && !(vld_q[b_q] && dom_rd_q == pick_q)) begin
          dom_we = 1'b1;
          dom_wa = b_q;
          dom_wd = pick_q;
          vld_d[b_q] = 1'b1;
          chg_d  = 1'b1;
        end
        idx_d   = idx_q + 7'd1;
        state_d = dtb_pkg::S_P_RD;
      end
      dtb_pkg::S_D_RD: begin
        if (idx_q == cnt_q) begin
          idx_d   = '0;
          state_d = dtb_pkg::S_O_RD;
        end else begin
          post_ra = rev[IdW-1:0];
          state_d = dtb_pkg::S_D_B;
        end
      end
      dtb_pkg::S_D_B: begin
        b_d = post_rd_q;
        if (post_rd_q == root_i) begin
          dep_we  = 1'b1;
          dep_wa  = root_i;
          dep_wd  = '0;
          idx_d   = idx_q + 7'd1;
          state_d = dtb_pkg::S_D_RD;
        end else if (vld_q[post_rd_q]) begin
          dom_ra  = post_rd_q;
          state_d = dtb_pkg::S_D_P;
        end else begin
          idx_d   = idx_q + 7'd1;
          state_d = dtb_pkg::S_D_RD;
        end
      end
      dtb_pkg::S_D_P: begin
        dep_ra  = dom_rd_q;
        state_d = dtb_pkg::S_D_W;
      end
      dtb_pkg::S_D_W: begin
        dep_we  = 1'b1;
        dep_wa  = b_q;
        dep_wd  = dep_rd_q + 6'd1;
        idx_d   = idx_q + 7'd1;
        state_d = dtb_pkg::S_D_RD;
      end
      dtb_pkg::S_O_RD: begin
        dom_ra  = idx_q[IdW-1:0];
        dep_ra  = idx_q[IdW-1:0];
        state_d = dtb_pkg::S_O_WR;
      end
      dtb_pkg::S_O_WR: begin
        res_d.valid     = 1'b1;
        res_d.blk_idx   = idx_q[IdW-1:0];
        res_d.reachable = vld_q[idx_q[IdW-1:0]];
        res_d.imm_dom   = vld_q[idx_q[IdW-1:0]] ? dom_rd_q : '0;
        res_d.depth     = vld_q[idx_q[IdW-1:0]] ? dep_rd_q : '0;
        res_d.overflow  = ovf_i;
        res_d.last      = (idx_q + 7'd1 == n_i);
        idx_d   = idx_q + 7'd1;
        state_d = dtb_pkg::S_O_RD;
        if (idx_q + 7'd1 == n_i) begin
          done_o  = 1'b1;
          state_d = dtb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dtb_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != dtb_pkg::S_IDLE);
  assign res_o  = res_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> top_q <= 7'(Ids))
    else $error("walk stack past capacity");
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid |-> $past(state_q == dtb_pkg::S_O_WR))
    else $error("result strobe outside emission");
  a_root_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtb_pkg::S_P_RD) |-> vld_q[root_i])
    else $error("entry block lost its dominator during passes");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == dtb_pkg::S_IDLE)
    else $error("sequencer still running after completion");

endmodule
